FILE: src/rfr_pkg.sv
// Shared types and constants of the response frame receiver.
// Used by the front, queue, back and top-level modules; depends on nothing.
package rfr_pkg;

  // Result status codes
  typedef enum logic [2:0] {
    ST_DATA    = 3'd0,
    ST_OK      = 3'd1,
    ST_NOACK   = 3'd2,
    ST_UNEXP   = 3'd3,
    ST_LENOVER = 3'd4,
    ST_CSUM    = 3'd5,
    ST_TIMEOUT = 3'd6
  } status_e;

  // Input item kinds
  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_TICK = 2'd1,
    KIND_ARM  = 2'd2
  } kind_e;

  // Configuration register indexes
  localparam logic [1:0] REG_CMD     = 2'd0;
  localparam logic [1:0] REG_MODE    = 2'd1;
  localparam logic [1:0] REG_TIMEOUT = 2'd2;

  // Frame bytes
  localparam logic [7:0] SUM_INIT = 8'hAD;
  localparam logic [7:0] MARK_B   = 8'h07;
  localparam logic [7:0] ACK_B    = 8'hF3;
  localparam logic [7:0] SOF_B    = 8'hF0;
  localparam logic [7:0] EOF_B    = 8'h0F;

  localparam logic [15:0] TIMEOUT_RST = 16'd150;
  localparam logic [15:0] TICKS_MAX   = 16'hFFFF;

  // Width of a payload count or index on the ports and in the queue
  localparam int COUNT_W = 5;

  typedef struct packed {
    logic [7:0]  expected_command;
    logic        ack_then_frame;
    logic [15:0] timeout_ticks;
  } cfg_t;

  // One queued job: emit count payload bytes, then a final result with status
  typedef struct packed {
    status_e              status;
    logic [COUNT_W-1:0]   count;
  } cmd_t;

endpackage

FILE: src/rfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module rfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 20,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/rfr_fifo.sv
// Two-entry job queue between the front and back parts.
// Depends on rfr_pkg for the job type.
module rfr_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rfr_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output rfr_pkg::cmd_t data_o
);

  rfr_pkg::cmd_t mem_q [2];
  logic          wptr_q, wptr_d;
  logic          rptr_q, rptr_d;
  logic [1:0]    count_q, count_d;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = ~wptr_q;
    end
    if (pop_i) begin
      rptr_d = ~rptr_q;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign data_o  = mem_q[rptr_q];

endmodule

FILE: src/rfr_front.sv
// Front part: accepts input items, tracks the frame, checksum and timeout,
// writes payload bytes to the RAM and queues jobs. Depends on rfr_pkg.
module rfr_front #(
  parameter int MAX_DATA = 20,
  localparam int AW = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rfr_pkg::cfg_t cfg_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [1:0]    kind_i,
  input  logic [7:0]    byte_value_i,
  input  logic          fifo_full_i,
  output logic          push_o,
  output rfr_pkg::cmd_t cmd_o,
  input  logic          replay_done_i,
  output logic          ram_we_o,
  output logic [AW-1:0] ram_waddr_o,
  output logic [7:0]    ram_wdata_o
);

  localparam int CNT_W = $clog2(MAX_DATA + 1);
  localparam int CW    = rfr_pkg::COUNT_W;

  typedef enum logic [11:0] {
    PH_IDLE = 12'b000000000001,
    PH_ACK0 = 12'b000000000010,
    PH_ACK1 = 12'b000000000100,
    PH_SOF0 = 12'b000000001000,
    PH_SOF1 = 12'b000000010000,
    PH_ZERO = 12'b000000100000,
    PH_CMD  = 12'b000001000000,
    PH_LEN  = 12'b000010000000,
    PH_DATA = 12'b000100000000,
    PH_CSUM = 12'b001000000000,
    PH_EOF0 = 12'b010000000000,
    PH_EOF1 = 12'b100000000000
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [7:0]         sum_q, sum_d;
  logic               seen_q, seen_d;
  logic [CNT_W-1:0]   len_q, len_d;
  logic [CNT_W-1:0]   rcv_q, rcv_d;
  logic [15:0]        ticks_q, ticks_d;
  logic               replay_q, replay_d;
  logic               accept;
  logic               add_en;
  logic               fail;
  rfr_pkg::status_e   fail_st;

  // Hold input while the queue is full or a payload replay owns the RAM
  assign in_ready_o  = !fifo_full_i && !replay_q;
  assign accept      = in_valid_i && in_ready_o;
  assign ram_waddr_o = rcv_q[AW-1:0];
  assign ram_wdata_o = byte_value_i;

  always_comb begin
    phase_d  = phase_q;
    sum_d    = sum_q;
    seen_d   = seen_q;
    len_d    = len_q;
    rcv_d    = rcv_q;
    ticks_d  = ticks_q;
    replay_d = replay_q;
    push_o   = 1'b0;
    cmd_o    = '{status: rfr_pkg::ST_OK, count: '0};
    ram_we_o = 1'b0;
    add_en   = 1'b0;
    fail     = 1'b0;
    fail_st  = rfr_pkg::ST_OK;
    if (accept) begin
      if (kind_i == rfr_pkg::KIND_ARM) begin
        phase_d = PH_ACK0;
        sum_d   = rfr_pkg::SUM_INIT;
        seen_d  = 1'b0;
        len_d   = '0;
        rcv_d   = '0;
        ticks_d = '0;
      end else if (kind_i == rfr_pkg::KIND_TICK && phase_q != PH_IDLE) begin
        if (ticks_q != rfr_pkg::TICKS_MAX) begin
          ticks_d = ticks_q + 16'd1;
        end
        if (ticks_d >= cfg_i.timeout_ticks) begin
          fail    = 1'b1;
          fail_st = rfr_pkg::ST_TIMEOUT;
        end
      end else if (kind_i == rfr_pkg::KIND_BYTE && phase_q != PH_IDLE) begin
        ticks_d = '0;
        case (phase_q)
          PH_ACK0: begin
            if (byte_value_i != rfr_pkg::MARK_B) begin
              fail    = 1'b1;
              fail_st = rfr_pkg::ST_NOACK;
            end else begin
              phase_d = PH_ACK1;
            end
          end
          PH_ACK1: begin
            if (byte_value_i != rfr_pkg::ACK_B) begin
              fail    = 1'b1;
              fail_st = rfr_pkg::ST_NOACK;
            end else if (!cfg_i.ack_then_frame) begin
              phase_d = PH_IDLE;
              push_o  = 1'b1;
            end else begin
              phase_d = PH_SOF0;
            end
          end
          PH_SOF0: begin
            if (byte_value_i != rfr_pkg::MARK_B) begin
              fail    = 1'b1;
              fail_st = rfr_pkg::ST_UNEXP;
            end else begin
              phase_d = PH_SOF1;
            end
          end
          PH_SOF1: begin
            if (byte_value_i != rfr_pkg::SOF_B) begin
              fail    = 1'b1;
              fail_st = rfr_pkg::ST_UNEXP;
            end else begin
              phase_d = PH_ZERO;
            end
          end
          PH_ZERO: begin
            if (byte_value_i != 8'h00) begin
              fail    = 1'b1;
              fail_st = rfr_pkg::ST_UNEXP;
            end else begin
              add_en  = 1'b1;
              phase_d = PH_CMD;
            end
          end
          PH_CMD: begin
            if (byte_value_i != cfg_i.expected_command) begin
              fail    = 1'b1;
              fail_st = rfr_pkg::ST_UNEXP;
            end else begin
              add_en  = 1'b1;
              phase_d = PH_LEN;
            end
          end
          PH_LEN: begin
            if (byte_value_i > 8'(MAX_DATA)) begin
              fail    = 1'b1;
              fail_st = rfr_pkg::ST_LENOVER;
            end else begin
              add_en  = 1'b1;
              len_d   = CNT_W'(byte_value_i);
              rcv_d   = '0;
              phase_d = (byte_value_i == 8'h00) ? PH_CSUM : PH_DATA;
            end
          end
          PH_DATA: begin
            ram_we_o = 1'b1;
            add_en   = 1'b1;
            rcv_d    = rcv_q + 1'b1;
            if (rcv_d >= len_q) begin
              phase_d = PH_CSUM;
            end
          end
          PH_CSUM: begin
            if (byte_value_i != sum_q) begin
              fail    = 1'b1;
              fail_st = rfr_pkg::ST_CSUM;
            end else begin
              phase_d = PH_EOF0;
            end
          end
          PH_EOF0: begin
            if (byte_value_i != rfr_pkg::MARK_B) begin
              fail    = 1'b1;
              fail_st = rfr_pkg::ST_UNEXP;
            end else begin
              phase_d = PH_EOF1;
            end
          end
          PH_EOF1: begin
            if (byte_value_i != rfr_pkg::EOF_B) begin
              fail    = 1'b1;
              fail_st = rfr_pkg::ST_UNEXP;
            end else begin
              phase_d     = PH_IDLE;
              push_o      = 1'b1;
              cmd_o.count = CW'(len_q);
              if (len_q != '0) begin
                replay_d = 1'b1;
              end
            end
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
        // Add to the checksum; only the first marker byte counts
        if (add_en) begin
          if (byte_value_i == rfr_pkg::MARK_B) begin
            if (!seen_q) begin
              seen_d = 1'b1;
              sum_d  = sum_q + byte_value_i;
            end
          end else begin
            sum_d = sum_q + byte_value_i;
          end
        end
      end
      if (fail) begin
        phase_d = PH_IDLE;
        push_o  = 1'b1;
        cmd_o   = '{status: fail_st, count: '0};
      end
    end
    if (replay_done_i) begin
      replay_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      sum_q    <= rfr_pkg::SUM_INIT;
      seen_q   <= 1'b0;
      len_q    <= '0;
      rcv_q    <= '0;
      ticks_q  <= '0;
      replay_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      sum_q    <= sum_d;
      seen_q   <= seen_d;
      len_q    <= len_d;
      rcv_q    <= rcv_d;
      ticks_q  <= ticks_d;
      replay_q <= replay_d;
    end
  end

  // A queued replay must lock out the input until the back part is done
  a_replay_lock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && cmd_o.count != '0 |=> replay_q && !in_ready_o)
    else $error("replay job queued without input lockout");

endmodule

FILE: src/rfr_back.sv
// Back part: pops jobs, replays stored payload bytes from the RAM and drives
// the result register. Depends on rfr_pkg.
module rfr_back #(
  parameter int MAX_DATA = 20,
  localparam int AW = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        fifo_empty_i,
  input  rfr_pkg::cmd_t               fifo_data_i,
  output logic                        pop_o,
  output logic                        ram_re_o,
  output logic [AW-1:0]               ram_raddr_o,
  input  logic [7:0]                  ram_rdata_i,
  output logic                        replay_done_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [2:0]                  status_o,
  output logic [7:0]                  data_value_o,
  output logic [rfr_pkg::COUNT_W-1:0] data_index_o,
  output logic                        last_o
);

  localparam int CNT_W = $clog2(MAX_DATA + 1);
  localparam int CW    = rfr_pkg::COUNT_W;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_RUN  = 3'b010,
    B_WAIT = 3'b100
  } bstate_e;

  bstate_e          state_q, state_d;
  rfr_pkg::status_e stat_q, stat_d;
  logic [CNT_W-1:0] n_q, n_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic             ovalid_q, ovalid_d;
  rfr_pkg::status_e ostat_q, ostat_d;
  logic [7:0]       odata_q, odata_d;
  logic [CW-1:0]    oidx_q, oidx_d;
  logic             olast_q, olast_d;
  logic             slot_free;

  assign slot_free   = !ovalid_q || out_ready_i;
  assign ram_raddr_o = idx_q[AW-1:0];

  always_comb begin
    state_d       = state_q;
    stat_d        = stat_q;
    n_d           = n_q;
    idx_d         = idx_q;
    ovalid_d      = ovalid_q && !out_ready_i;
    ostat_d       = ostat_q;
    odata_d       = odata_q;
    oidx_d        = oidx_q;
    olast_d       = olast_q;
    pop_o         = 1'b0;
    ram_re_o      = 1'b0;
    replay_done_o = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (!fifo_empty_i) begin
          pop_o   = 1'b1;
          stat_d  = fifo_data_i.status;
          n_d     = CNT_W'(fifo_data_i.count);
          idx_d   = '0;
          state_d = B_RUN;
        end
      end
      B_RUN: begin
        if (slot_free) begin
          if (idx_q < n_q) begin
            ram_re_o = 1'b1;
            state_d  = B_WAIT;
          end else begin
            ovalid_d = 1'b1;
            ostat_d  = stat_q;
            odata_d  = '0;
            oidx_d   = '0;
            olast_d  = 1'b1;
            state_d  = B_IDLE;
            if (n_q != '0) begin
              replay_done_o = 1'b1;
            end
          end
        end
      end
      B_WAIT: begin
        // Slot was freed when the read was issued; load the read data
        ovalid_d = 1'b1;
        ostat_d  = rfr_pkg::ST_DATA;
        odata_d  = ram_rdata_i;
        oidx_d   = CW'(idx_q);
        olast_d  = 1'b0;
        idx_d    = idx_q + 1'b1;
        state_d  = B_RUN;
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      ovalid_q <= 1'b0;
      stat_q   <= rfr_pkg::ST_OK;
      n_q      <= '0;
      idx_q    <= '0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      stat_q   <= stat_d;
      n_q      <= n_d;
      idx_q    <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ostat_q <= ostat_d;
    odata_q <= odata_d;
    oidx_q  <= oidx_d;
    olast_q <= olast_d;
  end

  assign out_valid_o  = ovalid_q;
  assign status_o     = ostat_q;
  assign data_value_o = odata_q;
  assign data_index_o = oidx_q;
  assign last_o       = olast_q;

  a_wait_slot_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_WAIT |-> !ovalid_q)
    else $error("read data arrives while result slot is occupied");

  a_wait_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_WAIT |=> ovalid_q && !olast_q)
    else $error("read data not loaded into result slot");

  a_data_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && !olast_q |-> ostat_q == rfr_pkg::ST_DATA && CNT_W'(oidx_q) < n_q)
    else $error("payload result outside the job's byte count");

endmodule

FILE: src/response_frame_receiver.sv
// Response frame receiver: a status-only result follows the accepting edge of its byte or
// tick through the queue push, the back pop and the result register; the first payload byte
// also passes the registered RAM read. Items are taken one per cycle while the queue is not
// full and no payload replay runs; after a good frame with payload bytes, input holds until
// each byte is read from the payload RAM with registered read data and the final result set.
// rst_ni clears all control state asynchronously and loads the register reset values;
// the payload RAM is not cleared. Depends on rfr_pkg, rfr_front, rfr_fifo, rfr_back, rfr_ram.
module response_frame_receiver #(
  parameter int MAX_DATA = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  byte_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [7:0]  data_value_o,
  output logic [4:0]  data_index_o,
  output logic        last_o
);

  localparam int AW = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;

  rfr_pkg::cfg_t cfg_q, cfg_d;
  logic          cfg_we;
  logic          push;
  rfr_pkg::cmd_t push_cmd;
  logic          fifo_full;
  logic          fifo_empty;
  logic          pop;
  rfr_pkg::cmd_t pop_cmd;
  logic          replay_done;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we) begin
      case (paddr[3:2])
        rfr_pkg::REG_CMD:     cfg_d.expected_command = pwdata[7:0];
        rfr_pkg::REG_MODE:    cfg_d.ack_then_frame   = pwdata[0];
        rfr_pkg::REG_TIMEOUT: cfg_d.timeout_ticks    = pwdata[15:0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      rfr_pkg::REG_CMD:     prdata = {24'd0, cfg_q.expected_command};
      rfr_pkg::REG_MODE:    prdata = {31'd0, cfg_q.ack_then_frame};
      rfr_pkg::REG_TIMEOUT: prdata = {16'd0, cfg_q.timeout_ticks};
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{expected_command: 8'd0, ack_then_frame: 1'b1,
                 timeout_ticks: rfr_pkg::TIMEOUT_RST};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  rfr_front #(.MAX_DATA(MAX_DATA)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .byte_value_i  (byte_value_i),
    .fifo_full_i   (fifo_full),
    .push_o        (push),
    .cmd_o         (push_cmd),
    .replay_done_i (replay_done),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata)
  );

  rfr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .empty_o (fifo_empty),
    .data_o  (pop_cmd)
  );

  rfr_ram #(.WIDTH(8), .DEPTH(MAX_DATA)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  rfr_back #(.MAX_DATA(MAX_DATA)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fifo_empty_i  (fifo_empty),
    .fifo_data_i   (pop_cmd),
    .pop_o         (pop),
    .ram_re_o      (ram_re),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata),
    .replay_done_o (replay_done),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .data_value_o  (data_value_o),
    .data_index_o  (data_index_o),
    .last_o        (last_o)
  );

endmodule
